// ===== rtl/prs_pkg.sv =====
// prs_pkg: shared types and constants for the prime range statistics block
// payload structs, controller state encoding and the command/status bundles
// no dependencies; compiled first

package prs_pkg;

	// default sieve limit
	localparam int MAX_VALUE_DEF = 65535;

	// fixed field widths
	localparam int VAL_W   = 16;
	localparam int KEPT_W  = 2;
	localparam int COUNT_W = 17;

	// primes_kept saturates at three
	localparam logic [KEPT_W-1:0] KEPT_MAX = 2'd3;

	typedef struct packed {
		logic [VAL_W-1:0] range_start;
		logic [VAL_W-1:0] range_end;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]   largest_prime;
		logic [VAL_W-1:0]   second_largest_prime;
		logic [VAL_W-1:0]   third_largest_prime;
		logic [KEPT_W-1:0]  primes_kept;
		logic [COUNT_W-1:0] prime_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INIT,
		ST_OUTER,
		ST_TEST,
		ST_MARK,
		ST_SCAN,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic init_step;
		logic p_start;
		logic p_read;
		logic p_next;
		logic m_start;
		logic m_step;
		logic scan_start;
		logic scan_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic init_last;
		logic sq_gt_hi;
		logic bit_set;
		logic m_gt_hi;
		logic scan_done;
	} status_t;

endpackage

// ===== rtl/prs_stream_if.sv =====
// prs_stream_if: valid/ready channel carrying one payload struct
// payload type set per instance; used with prs_pkg structs

interface prs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/prs_ctrl.sv =====
// prs_ctrl: sequencing state machine of the prime range statistics block
// depends on prs_pkg for state_t, cmd_t and status_t

module prs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  prs_pkg::status_t  status,
	output prs_pkg::cmd_t     cmd
);

	prs_pkg::state_t state_q;
	prs_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			prs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = prs_pkg::ST_CHECK;
				end
			end
			prs_pkg::ST_CHECK: begin
				if (status.empty) begin
					state_nxt = prs_pkg::ST_DONE;
				end else begin
					state_nxt = prs_pkg::ST_INIT;
				end
			end
			prs_pkg::ST_INIT: begin
				cmd.init_step = 1'b1;
				if (status.init_last) begin
					cmd.p_start = 1'b1;
					state_nxt   = prs_pkg::ST_OUTER;
				end
			end
			prs_pkg::ST_OUTER: begin
				if (status.sq_gt_hi) begin
					cmd.scan_start = 1'b1;
					state_nxt      = prs_pkg::ST_SCAN;
				end else begin
					cmd.p_read = 1'b1;
					state_nxt  = prs_pkg::ST_TEST;
				end
			end
			prs_pkg::ST_TEST: begin
				if (status.bit_set) begin
					cmd.m_start = 1'b1;
					state_nxt   = prs_pkg::ST_MARK;
				end else begin
					cmd.p_next = 1'b1;
					state_nxt  = prs_pkg::ST_OUTER;
				end
			end
			prs_pkg::ST_MARK: begin
				if (status.m_gt_hi) begin
					cmd.p_next = 1'b1;
					state_nxt  = prs_pkg::ST_OUTER;
				end else begin
					cmd.m_step = 1'b1;
				end
			end
			prs_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_done) begin
					state_nxt = prs_pkg::ST_DONE;
				end
			end
			prs_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_nxt = prs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = prs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/prs_datapath.sv =====
// prs_datapath: bitmap memory, sieve counters and scan accumulators
// depends on prs_pkg for cmd_t, status_t, rsp_t and field widths

module prs_datapath #(
	parameter int MAX_VALUE = prs_pkg::MAX_VALUE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  prs_pkg::cmd_t              cmd,
	output prs_pkg::status_t           status,
	input  logic [prs_pkg::VAL_W-1:0]  range_start,
	input  logic [prs_pkg::VAL_W-1:0]  range_end,
	output prs_pkg::rsp_t              result
);

	localparam int VW    = $clog2(MAX_VALUE + 1);
	localparam int DEPTH = MAX_VALUE + 1;

	logic prime_bitmap [DEPTH];

	logic [VW-1:0] lo_q;
	logic [VW-1:0] hi_q;
	logic          empty_q;
	logic [VW:0]   v_q;
	logic [VW-1:0] p_q;
	logic [VW:0]   sq_q;
	logic [VW:0]   m_q;
	logic          rd_q;
	logic          rv_s1;
	logic [VW-1:0] addr_s1;
	logic [VW:0]   count_q;
	logic [VW-1:0] t0_q;
	logic [VW-1:0] t1_q;
	logic [VW-1:0] t2_q;
	logic [prs_pkg::KEPT_W-1:0] kept_q;

	logic [VW-1:0] hi_sat;
	logic          empty_nxt;
	logic [VW:0]   hi_ext;
	logic          scan_issue;
	logic          we;
	logic [VW-1:0] waddr;
	logic          wdata;
	logic          re;
	logic [VW-1:0] raddr;

	// end of range clipped to the sieve limit
	always_comb begin
		if (32'(range_end) > 32'(MAX_VALUE)) begin
			hi_sat = VW'(MAX_VALUE);
		end else begin
			hi_sat = VW'(range_end);
		end
		empty_nxt = 32'(range_start) > 32'(hi_sat);
	end

	assign hi_ext     = {1'b0, hi_q};
	assign scan_issue = cmd.scan_step && (v_q <= hi_ext);

	// single write and single read port
	assign we    = cmd.init_step | cmd.m_step;
	assign waddr = cmd.init_step ? v_q[VW-1:0] : m_q[VW-1:0];
	assign wdata = cmd.init_step & (v_q >= (VW+1)'(2));
	assign re    = cmd.p_read | scan_issue;
	assign raddr = cmd.p_read ? p_q : v_q[VW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			prime_bitmap[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= prime_bitmap[raddr];
		end
	end

	// scan read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q    <= VW'(range_start);
			hi_q    <= hi_sat;
			empty_q <= empty_nxt;
		end

		if (cmd.load) begin
			v_q <= '0;
		end else if (cmd.scan_start) begin
			v_q <= {1'b0, lo_q};
		end else if (cmd.init_step || scan_issue) begin
			v_q <= v_q + 1'b1;
		end

		// p and its square move together
		if (cmd.p_start) begin
			p_q  <= VW'(2);
			sq_q <= (VW+1)'(4);
		end else if (cmd.p_next) begin
			p_q  <= p_q + 1'b1;
			sq_q <= sq_q + {p_q, 1'b1};
		end

		if (cmd.m_start) begin
			m_q <= sq_q;
		end else if (cmd.m_step) begin
			m_q <= m_q + {1'b0, p_q};
		end

		if (scan_issue) begin
			addr_s1 <= v_q[VW-1:0];
		end

		if (cmd.load) begin
			count_q <= '0;
			t0_q    <= '0;
			t1_q    <= '0;
			t2_q    <= '0;
			kept_q  <= '0;
		end else if (rv_s1 && rd_q) begin
			count_q <= count_q + 1'b1;
			t2_q    <= t1_q;
			t1_q    <= t0_q;
			t0_q    <= addr_s1;
			if (kept_q != prs_pkg::KEPT_MAX) begin
				kept_q <= kept_q + 1'b1;
			end
		end
	end

	always_comb begin
		status.empty     = empty_q;
		status.init_last = (v_q[VW-1:0] == hi_q);
		status.sq_gt_hi  = (sq_q > hi_ext);
		status.bit_set   = rd_q;
		status.m_gt_hi   = (m_q > hi_ext);
		status.scan_done = (v_q > hi_ext) && !rv_s1;
	end

	always_comb begin
		result.largest_prime        = prs_pkg::VAL_W'(t0_q);
		result.second_largest_prime = prs_pkg::VAL_W'(t1_q);
		result.third_largest_prime  = prs_pkg::VAL_W'(t2_q);
		result.primes_kept          = kept_q;
		result.prime_count          = prs_pkg::COUNT_W'(count_q);
	end

endmodule

// ===== rtl/prime_range_statistics.sv =====
// prime_range_statistics: top level, prime count and top three primes of a range
// depends on prs_pkg, prs_stream_if, prs_ctrl and prs_datapath
//
// channel  dir  payload                         transaction
// req      in   prs_pkg::req_t (start, end)     one range request
// rsp      out  prs_pkg::rsp_t (top3, kept, n)  one result per request
//
// one request at a time; req.ready is high only while the block is idle
// each request fills the bitmap up to hi, crosses out the multiples of each prime p
//   with p*p <= hi from p*p upward, then scans lo to hi for the count and top three
// the bitmap memory has one write port and one read port
// an empty range (start above end) skips the sieve and goes from check to done
// the result is held on rsp until taken; rsp stalls delay the next request
// arst_n returns the controller to idle; the bitmap needs no clearing

module prime_range_statistics #(
	parameter int MAX_VALUE = prs_pkg::MAX_VALUE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	prs_stream_if.sink   req,
	prs_stream_if.source rsp
);

	prs_pkg::cmd_t    cmd;
	prs_pkg::status_t status;
	prs_pkg::rsp_t    result;
	logic             in_ready;
	logic             out_valid;

	// sequencing: fill, sieve, scan, hand over
	prs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// bitmap memory and counters
	prs_datapath #(
		.MAX_VALUE (MAX_VALUE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.range_start (req.data.range_start),
		.range_end   (req.data.range_end),
		.result      (result)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;
	// result registers hold still while the result waits
	assign rsp.data  = result;

	// no new request taken while a result is pending
	a_no_accept_while_pending: assert property (
		@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready
	) else $error("request accepted while a result is pending");

	// a result never appears in the cycle right after a request is taken
	a_no_instant_result: assert property (
		@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !rsp.valid
	) else $error("result presented right after acceptance");

	// below saturation the kept count equals the prime count
	a_kept_matches_count: assert property (
		@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.primes_kept == prs_pkg::KEPT_MAX ||
			prs_pkg::COUNT_W'(rsp.data.primes_kept) == rsp.data.prime_count)
	) else $error("primes_kept disagrees with prime_count");

	// with nothing kept, largest_prime reads zero
	a_empty_fields_zero: assert property (
		@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.primes_kept == '0) |-> (rsp.data.largest_prime == '0)
	) else $error("largest_prime nonzero with nothing kept");

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for prime_range_statistics (range prime count, top three)
// depends on prs_pkg, prs_stream_if and the prime_range_statistics rtl
// directed table first, then random ranges, checked against hand-written answers or an in-bench sieve

module tb_top;

	// generous ceiling for the whole run, which includes large sieves
	localparam int CYCLE_LIMIT  = 8_000_000;
	localparam int RANDOM_ITEMS = 78;
	localparam int SIEVE_TOP    = prs_pkg::MAX_VALUE_DEF;

	// one row of the directed table; typed rows carry a hand-written answer
	typedef struct {
		logic [prs_pkg::VAL_W-1:0] lo;
		logic [prs_pkg::VAL_W-1:0] hi;
		bit                        typed;
		prs_pkg::rsp_t             want;
	} range_row_t;

	// outstanding request with the answer it should produce
	typedef struct {
		prs_pkg::req_t ask;
		prs_pkg::rsp_t want;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n;

	prs_stream_if #(.payload_t(prs_pkg::req_t)) req_if ();
	prs_stream_if #(.payload_t(prs_pkg::rsp_t)) rsp_if ();

	prime_range_statistics DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #10 clk = ~clk;

	pending_t pending_results[$];
	bit       prime_map [0:SIEVE_TOP];
	int       mismatches = 0;
	int       cycles = 0;
	int       tx_calm = 0;

	// watchdog: any hang or lost result lands here
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// wait before the next transaction, drawn at random, with runs of back-to-back ones
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(3, 8);
		return $urandom_range(0, 10);
	endfunction

	// rebuild the bitmap up to the range end, then scan the range bottom-up
	// keeping the last three primes seen, so the newest one is the largest
	function automatic prs_pkg::rsp_t range_primes(input logic [prs_pkg::VAL_W-1:0] lo_in,
			input logic [prs_pkg::VAL_W-1:0] hi_in);
		prs_pkg::rsp_t r;
		int            lo, hi, p, m, v;
		r  = '0;
		lo = int'(lo_in);
		hi = int'(hi_in);
		if (hi > SIEVE_TOP)
			hi = SIEVE_TOP;
		if (lo <= hi) begin
			for (v = 0; v <= hi; v++)
				prime_map[v] = (v >= 2);
			for (p = 2; p * p <= hi; p++) begin
				if (prime_map[p]) begin
					for (m = p * p; m <= hi; m += p)
						prime_map[m] = 1'b0;
				end
			end
			for (v = lo; v <= hi; v++) begin
				if (prime_map[v]) begin
					r.prime_count          = r.prime_count + 1'b1;
					r.third_largest_prime  = r.second_largest_prime;
					r.second_largest_prime = r.largest_prime;
					r.largest_prime        = v[prs_pkg::VAL_W-1:0];
					if (r.primes_kept != prs_pkg::KEPT_MAX)
						r.primes_kept = r.primes_kept + 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic range_row_t make_row(input int lo, input int hi, input bit typed,
			input int p1 = 0, input int p2 = 0, input int p3 = 0,
			input int kept = 0, input int count = 0);
		range_row_t row;
		row.lo                        = prs_pkg::VAL_W'(lo);
		row.hi                        = prs_pkg::VAL_W'(hi);
		row.typed                     = typed;
		row.want.largest_prime        = prs_pkg::VAL_W'(p1);
		row.want.second_largest_prime = prs_pkg::VAL_W'(p2);
		row.want.third_largest_prime  = prs_pkg::VAL_W'(p3);
		row.want.primes_kept          = prs_pkg::KEPT_W'(kept);
		row.want.prime_count          = prs_pkg::COUNT_W'(count);
		return row;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want,
			input prs_pkg::req_t ask);
		mismatches++;
		$display("mismatch %s: got %0d want %0d (start %0d end %0d) at cycle %0d",
			what, got, want, ask.range_start, ask.range_end, cycles);
	endtask

	// compare one result transaction against the oldest outstanding request
	task automatic check_result(input prs_pkg::rsp_t got);
		pending_t exp;
		if (pending_results.size() == 0) begin
			report_mismatch("result with no request pending", int'(got.prime_count), 0,
				'0);
			return;
		end
		exp = pending_results.pop_front();
		if (got.largest_prime !== exp.want.largest_prime)
			report_mismatch("largest_prime", int'(got.largest_prime),
				int'(exp.want.largest_prime), exp.ask);
		if (got.second_largest_prime !== exp.want.second_largest_prime)
			report_mismatch("second_largest_prime", int'(got.second_largest_prime),
				int'(exp.want.second_largest_prime), exp.ask);
		if (got.third_largest_prime !== exp.want.third_largest_prime)
			report_mismatch("third_largest_prime", int'(got.third_largest_prime),
				int'(exp.want.third_largest_prime), exp.ask);
		if (got.primes_kept !== exp.want.primes_kept)
			report_mismatch("primes_kept", int'(got.primes_kept),
				int'(exp.want.primes_kept), exp.ask);
		if (got.prime_count !== exp.want.prime_count)
			report_mismatch("prime_count", int'(got.prime_count),
				int'(exp.want.prime_count), exp.ask);
	endtask

	// one request transaction; valid stays high across back-to-back requests
	task automatic send_range(input logic [prs_pkg::VAL_W-1:0] lo,
			input logic [prs_pkg::VAL_W-1:0] hi, input bit typed, input prs_pkg::rsp_t want);
		int       gap;
		pending_t exp;
		gap = draw_wait(tx_calm);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= '{range_start: lo, range_end: hi};
		do @(posedge clk); while (!req_if.ready);
		exp.ask.range_start = lo;
		exp.ask.range_end   = hi;
		exp.want            = typed ? want : range_primes(lo, hi);
		pending_results     = {pending_results, exp};
	endtask

	// result side: either ready waits high, or it stays low until valid shows
	// up and then for the rest of a drawn wait, so stalls hit a held result
	initial begin
		int stall;
		int rx_calm;
		rx_calm      = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(rx_calm);
			if (stall == 0) begin
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= 1'b0;
				do @(posedge clk); while (!rsp_if.valid);
				repeat (stall - 1) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end
			do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
			check_result(rsp_if.data);
		end
	end

	initial begin
		range_row_t    rows[$];
		int            i, sel, lo, hi, width;
		prs_pkg::rsp_t none;
		none         = '0;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;

		// small ends: nothing below two is prime
		rows = {rows, make_row(0, 0, 1)};
		rows = {rows, make_row(0, 1, 1)};
		rows = {rows, make_row(1, 1, 1)};
		// first primes, mostly partial fills of the top three
		rows = {rows, make_row(2, 2, 1, 2, 0, 0, 1, 1)};
		rows = {rows, make_row(0, 2, 1, 2, 0, 0, 1, 1)};
		rows = {rows, make_row(2, 3, 1, 3, 2, 0, 2, 2)};
		rows = {rows, make_row(1, 3, 1, 3, 2, 0, 2, 2)};
		rows = {rows, make_row(0, 4, 1, 3, 2, 0, 2, 2)};
		rows = {rows, make_row(0, 10, 0)};
		rows = {rows, make_row(11, 11, 1, 11, 0, 0, 1, 1)};
		// ranges holding only composites, then sieve-checked ranges up to 100
		rows = {rows, make_row(14, 16, 1)};
		rows = {rows, make_row(24, 28, 1)};
		rows = {rows, make_row(0, 100, 0)};
		rows = {rows, make_row(90, 100, 0)};
		// empty ranges, start above end
		rows = {rows, make_row(5, 4, 1)};
		rows = {rows, make_row(3, 2, 1)};
		rows = {rows, make_row(65535, 0, 1)};
		rows = {rows, make_row(65535, 65534, 1)};
		rows = {rows, make_row(16'hAAAA, 16'h5555, 1)};
		// wider ranges, answered by the sieve in the bench
		rows = {rows, make_row(1000, 1030, 0)};
		rows = {rows, make_row(0, 1023, 0)};
		rows = {rows, make_row(0, 65535, 0)};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[k])
			send_range(rows[k].lo, rows[k].hi, rows[k].typed, rows[k].want);

		// random part: mostly small sieves to keep the run short, two large ones
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			sel = $urandom_range(0, 19);
			if (i == 33 || i == 66) begin
				hi = $urandom_range(32768, 65535);
				lo = $urandom_range(0, hi);
			end else if (sel < 3) begin
				// empty range with a start anywhere above the end
				hi = $urandom_range(0, 1023);
				lo = $urandom_range(hi + 1, 65535);
			end else if (sel < 6) begin
				hi = $urandom_range(0, 20);
				lo = $urandom_range(0, hi);
			end else if (sel < 12) begin
				// narrow window high in the sieve
				hi    = $urandom_range(2, 1023);
				width = (hi < 64) ? hi : 64;
				lo    = hi - $urandom_range(0, width);
			end else begin
				hi = $urandom_range(2, 1023);
				lo = $urandom_range(0, hi);
			end
			send_range(prs_pkg::VAL_W'(lo), prs_pkg::VAL_W'(hi), 1'b0, none);
		end
		req_if.valid <= 1'b0;

		// drain outstanding results, then a short settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
